/* rtl/core/lfp_pkg.sv */
// Shared types and constants for the location frame parser.
package lfp_pkg;

    localparam logic [3:0] FRAME_LAST_POS = 4'd11;
    localparam logic [3:0] COUNT_MAX      = 4'd15;
    localparam logic [3:0] POS_HDR0       = 4'd0;
    localparam logic [3:0] POS_HDR1       = 4'd1;
    localparam logic [3:0] POS_KIND       = 4'd2;
    localparam logic [3:0] POS_LAT0       = 4'd3;
    localparam logic [3:0] POS_LON0       = 4'd7;
    localparam int         WORD_BYTES     = 4;

    localparam logic [7:0] HDR0_BYTE    = 8'hAA;
    localparam logic [7:0] HDR1_BYTE    = 8'h55;
    localparam logic [7:0] KIND_CURRENT = 8'h01;
    localparam logic [7:0] KIND_HOME    = 8'h02;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_LENGTH   = 3'd1,
        STATUS_HEADER   = 3'd2,
        STATUS_CHECKSUM = 3'd3,
        STATUS_KIND     = 3'd4
    } status_t;

    typedef struct packed {
        logic       valid;
        logic       last_byte;
        logic [7:0] data_byte;
    } beat_t;

endpackage

/* rtl/core/lfp_in_stage.sv */
// Input register stage that holds one received beat for the frame accumulator.
module lfp_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic              result_blocked,
    output lfp_pkg::beat_t    beat
);

    logic       valid_reg;
    logic       valid_next;
    logic       last_reg;
    logic [7:0] data_reg;
    logic       hold;

    // A closing beat may only move on when the result register has room.
    assign hold     = valid_reg && last_reg && result_blocked;
    assign in_stall = hold;

    assign valid_next = hold ? 1'b1 : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold)
        begin
            last_reg <= last_byte;
            data_reg <= data_byte;
        end
    end

    assign beat.valid     = valid_reg && !hold;
    assign beat.last_byte = last_reg;
    assign beat.data_byte = data_reg;

endmodule

/* rtl/core/lfp_frame_acc.sv */
// Frame accumulator: byte count, header check, running XOR, field capture and result register.
module lfp_frame_acc (
    input  logic              clk,
    input  logic              rst_n,
    input  lfp_pkg::beat_t    beat,
    output logic              result_blocked,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        status,
    output logic [1:0]        location_kind,
    output logic [31:0]       latitude_bits,
    output logic [31:0]       longitude_bits
);

    logic [3:0]  count_reg;
    logic [3:0]  count_next;
    logic        hdr_ok_reg;
    logic        hdr_ok_next;
    logic [7:0]  xor_reg;
    logic [7:0]  xor_next;
    logic [7:0]  kind_reg;
    logic [7:0]  kind_next;
    logic [31:0] lat_reg;
    logic [31:0] lat_next;
    logic [31:0] lon_reg;
    logic [31:0] lon_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [2:0]  status_reg;
    logic [1:0]  kind_out_reg;
    logic [31:0] lat_out_reg;
    logic [31:0] lon_out_reg;

    lfp_pkg::status_t res_status;
    logic             finish;

    assign result_blocked = out_valid_reg && out_stall;
    assign finish         = beat.valid && beat.last_byte;

    always_comb
    begin
        hdr_ok_next = hdr_ok_reg;
        kind_next   = kind_reg;
        lat_next    = lat_reg;
        lon_next    = lon_reg;
        if (count_reg == lfp_pkg::POS_HDR0 && beat.data_byte != lfp_pkg::HDR0_BYTE)
        begin
            hdr_ok_next = 1'b0;
        end
        if (count_reg == lfp_pkg::POS_HDR1 && beat.data_byte != lfp_pkg::HDR1_BYTE)
        begin
            hdr_ok_next = 1'b0;
        end
        if (count_reg == lfp_pkg::POS_KIND)
        begin
            kind_next = beat.data_byte;
        end
        for (int i = 0; i < lfp_pkg::WORD_BYTES; i++)
        begin
            if (count_reg == lfp_pkg::POS_LAT0 + 4'(i))
            begin
                lat_next[8*i +: 8] = beat.data_byte;
            end
            if (count_reg == lfp_pkg::POS_LON0 + 4'(i))
            begin
                lon_next[8*i +: 8] = beat.data_byte;
            end
        end
        xor_next   = xor_reg ^ beat.data_byte;
        count_next = (count_reg == lfp_pkg::COUNT_MAX) ? count_reg : count_reg + 4'd1;
    end

    always_comb
    begin
        priority if (count_reg != lfp_pkg::FRAME_LAST_POS)
        begin
            res_status = lfp_pkg::STATUS_LENGTH;
        end
        else if (!hdr_ok_reg)
        begin
            res_status = lfp_pkg::STATUS_HEADER;
        end
        else if (xor_reg != beat.data_byte)
        begin
            res_status = lfp_pkg::STATUS_CHECKSUM;
        end
        else if (kind_reg != lfp_pkg::KIND_CURRENT && kind_reg != lfp_pkg::KIND_HOME)
        begin
            res_status = lfp_pkg::STATUS_KIND;
        end
        else
        begin
            res_status = lfp_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            hdr_ok_reg <= 1'b1;
            xor_reg    <= '0;
            kind_reg   <= '0;
            lat_reg    <= '0;
            lon_reg    <= '0;
        end
        else if (beat.valid)
        begin
            if (beat.last_byte)
            begin
                count_reg  <= '0;
                hdr_ok_reg <= 1'b1;
                xor_reg    <= '0;
                kind_reg   <= '0;
                lat_reg    <= '0;
                lon_reg    <= '0;
            end
            else
            begin
                count_reg  <= count_next;
                hdr_ok_reg <= hdr_ok_next;
                xor_reg    <= xor_next;
                kind_reg   <= kind_next;
                lat_reg    <= lat_next;
                lon_reg    <= lon_next;
            end
        end
    end

    assign out_valid_next = finish ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // The data fields are only passed on for a clean frame.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            status_reg <= res_status;
            if (res_status == lfp_pkg::STATUS_OK)
            begin
                kind_out_reg <= kind_reg[1:0];
                lat_out_reg  <= lat_reg;
                lon_out_reg  <= lon_reg;
            end
            else
            begin
                kind_out_reg <= '0;
                lat_out_reg  <= '0;
                lon_out_reg  <= '0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign location_kind  = kind_out_reg;
    assign latitude_bits  = lat_out_reg;
    assign longitude_bits = lon_out_reg;

endmodule

/* rtl/core/location_frame_parser.sv */
// Top level of the location frame parser: input stage, frame accumulator and checks.
//
// The input channel carries one frame byte per beat, with last_byte set on the
// final byte of a frame. A frame is 0xAA, 0x55, a kind byte, latitude and
// longitude as little-endian 32-bit words, and an XOR checksum byte.
// The output channel carries one result beat per frame: status, kind and the
// two raw single-precision bit patterns, which read zero on any error.
// Bytes that do not close a frame give no output beat.
// Throughput is one byte per cycle while in_stall is low: each byte needs
// only a counter step, an XOR and a byte-lane write between the input
// register and the result register, which a closing byte passes in turn.
// When the receiver stalls, the result register holds its beat; further bytes
// of the next frame keep flowing until the next closing byte reaches the input
// register, and in_stall rises only then.
// Reset empties both registers and returns the frame state to byte zero with
// the header marked good.
module location_frame_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [1:0]  location_kind,
    output logic [31:0] latitude_bits,
    output logic [31:0] longitude_bits
);

    lfp_pkg::beat_t beat;
    logic           result_blocked;

    lfp_in_stage u_in_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .result_blocked (result_blocked),
        .beat           (beat)
    );

    lfp_frame_acc u_frame_acc (
        .clk            (clk),
        .rst_n          (rst_n),
        .beat           (beat),
        .result_blocked (result_blocked),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .location_kind  (location_kind),
        .latitude_bits  (latitude_bits),
        .longitude_bits (longitude_bits)
    );

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the result register was free");

    a_error_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != lfp_pkg::STATUS_OK) |->
        (location_kind == 2'd0 && latitude_bits == 32'd0 && longitude_bits == 32'd0))
        else $error("data fields not cleared on an error result");

    a_ok_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == lfp_pkg::STATUS_OK) |->
        (location_kind == lfp_pkg::KIND_CURRENT[1:0] ||
         location_kind == lfp_pkg::KIND_HOME[1:0]))
        else $error("clean frame reported with an invalid kind");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= lfp_pkg::STATUS_KIND))
        else $error("status code out of range");

endmodule

/* test/location_frame_parser_test.sv */
// Self-checking testbench for the location frame parser: directed and random frames, random gaps and stalls.
module location_frame_parser_test;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } wire_beat_t;

    typedef struct packed {
        lfp_pkg::status_t status;
        logic [1:0]       kind;
        logic [31:0]      lat;
        logic [31:0]      lon;
    } location_report_t;

    localparam int STIM_BYTES = 550;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [1:0]  location_kind;
    logic [31:0] latitude_bits;
    logic [31:0] longitude_bits;

    wire_beat_t       wire_bytes[$];
    logic [7:0]       frame_buf[$];
    location_report_t due_reports[$];

    logic        in_took = 1'b0;
    logic        out_took = 1'b0;
    int          in_gap = 0;
    int          in_calm = 0;
    int          result_wait = 0;
    int          out_calm = 0;
    int          idle_cycles = 0;
    int          mismatches = 0;

    logic [3:0]  frame_pos = 4'd0;
    logic        header_ok = 1'b1;
    logic [7:0]  frame_xor = 8'd0;
    logic [7:0]  kind_seen = 8'd0;
    logic [31:0] lat_acc = 32'd0;
    logic [31:0] lon_acc = 32'd0;

    location_frame_parser i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .location_kind  (location_kind),
        .latitude_bits  (latitude_bits),
        .longitude_bits (longitude_bits)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [3:0]       pos;
        logic [7:0]       xor_prev;
        location_report_t rep;
        pos = frame_pos;
        xor_prev = frame_xor;
        if (pos == lfp_pkg::POS_HDR0 && b != lfp_pkg::HDR0_BYTE)
            header_ok = 1'b0;
        if (pos == lfp_pkg::POS_HDR1 && b != lfp_pkg::HDR1_BYTE)
            header_ok = 1'b0;
        if (pos == lfp_pkg::POS_KIND)
            kind_seen = b;
        if (pos >= lfp_pkg::POS_LAT0 && pos < lfp_pkg::POS_LON0)
            lat_acc |= {24'd0, b} << (8 * (pos - lfp_pkg::POS_LAT0));
        if (pos >= lfp_pkg::POS_LON0 && pos < lfp_pkg::POS_LON0 + lfp_pkg::WORD_BYTES)
            lon_acc |= {24'd0, b} << (8 * (pos - lfp_pkg::POS_LON0));
        frame_xor ^= b;
        if (frame_pos != lfp_pkg::COUNT_MAX)
            frame_pos++;
        if (last)
        begin
            if (pos != lfp_pkg::FRAME_LAST_POS)
                rep.status = lfp_pkg::STATUS_LENGTH;
            else if (!header_ok)
                rep.status = lfp_pkg::STATUS_HEADER;
            else if (xor_prev != b)
                rep.status = lfp_pkg::STATUS_CHECKSUM;
            else if (kind_seen != lfp_pkg::KIND_CURRENT && kind_seen != lfp_pkg::KIND_HOME)
                rep.status = lfp_pkg::STATUS_KIND;
            else
                rep.status = lfp_pkg::STATUS_OK;
            if (rep.status == lfp_pkg::STATUS_OK)
            begin
                rep.kind = kind_seen[1:0];
                rep.lat = lat_acc;
                rep.lon = lon_acc;
            end
            else
            begin
                rep.kind = 2'd0;
                rep.lat = 32'd0;
                rep.lon = 32'd0;
            end
            due_reports.push_back(rep);
            frame_pos = 4'd0;
            header_ok = 1'b1;
            frame_xor = 8'd0;
            kind_seen = 8'd0;
            lat_acc = 32'd0;
            lon_acc = 32'd0;
        end
    endtask

    task automatic check_report();
        location_report_t want;
        if (due_reports.size() == 0)
        begin
            $display("%0t: expected no result, got status %0d kind %0d lat %h lon %h",
                     $time, status, location_kind, latitude_bits, longitude_bits);
            mismatches++;
        end
        else
        begin
            want = due_reports.pop_front();
            if (status !== want.status)
            begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, status);
                mismatches++;
            end
            if (location_kind !== want.kind)
            begin
                $display("%0t: kind expected %0d, got %0d", $time, want.kind, location_kind);
                mismatches++;
            end
            if (latitude_bits !== want.lat)
            begin
                $display("%0t: latitude expected %h, got %h", $time, want.lat, latitude_bits);
                mismatches++;
            end
            if (longitude_bits !== want.lon)
            begin
                $display("%0t: longitude expected %h, got %h", $time, want.lon, longitude_bits);
                mismatches++;
            end
        end
    endtask

    task automatic build_frame(input logic [7:0] h0, input logic [7:0] h1,
                               input logic [7:0] kind, input logic [31:0] lat,
                               input logic [31:0] lon);
        logic [7:0] sum;
        frame_buf.delete();
        frame_buf.push_back(h0);
        frame_buf.push_back(h1);
        frame_buf.push_back(kind);
        for (int k = 0; k < lfp_pkg::WORD_BYTES; k++)
            frame_buf.push_back(lat[8 * k +: 8]);
        for (int k = 0; k < lfp_pkg::WORD_BYTES; k++)
            frame_buf.push_back(lon[8 * k +: 8]);
        sum = 8'd0;
        foreach (frame_buf[i])
            sum ^= frame_buf[i];
        frame_buf.push_back(sum);
    endtask

    task automatic queue_frame();
        wire_beat_t beat;
        foreach (frame_buf[i])
        begin
            beat.data = frame_buf[i];
            beat.last = (i == frame_buf.size() - 1);
            wire_bytes.push_back(beat);
        end
        frame_buf.delete();
    endtask

    function automatic logic [7:0] bad_kind();
        logic [7:0] k;
        k = 8'($urandom_range(0, 255));
        while (k == lfp_pkg::KIND_CURRENT || k == lfp_pkg::KIND_HOME)
            k = 8'($urandom_range(0, 255));
        return k;
    endfunction

    task automatic queue_random_frame();
        logic [7:0] h0;
        logic [7:0] h1;
        int         len;
        int         pick;
        h0 = lfp_pkg::HDR0_BYTE;
        h1 = lfp_pkg::HDR1_BYTE;
        pick = $urandom_range(0, 9);
        case (pick)
            4:
            begin
                case ($urandom_range(0, 2))
                    0: h0 ^= 8'($urandom_range(1, 255));
                    1: h1 ^= 8'($urandom_range(1, 255));
                    default:
                    begin
                        h0 ^= 8'($urandom_range(1, 255));
                        h1 ^= 8'($urandom_range(1, 255));
                    end
                endcase
                build_frame(h0, h1, $urandom_range(0, 1) ? bad_kind() : 8'($urandom_range(1, 2)),
                            pick_word(), pick_word());
                if ($urandom_range(0, 1))
                    frame_buf[lfp_pkg::FRAME_LAST_POS] ^= 8'($urandom_range(1, 255));
            end
            5:
            begin
                build_frame(h0, h1, $urandom_range(0, 1) ? bad_kind() : 8'($urandom_range(1, 2)),
                            pick_word(), pick_word());
                frame_buf[lfp_pkg::FRAME_LAST_POS] ^= 8'($urandom_range(1, 255));
            end
            6:
                build_frame(h0, h1, bad_kind(), pick_word(), pick_word());
            7:
            begin
                len = $urandom_range(1, 11);
                if ($urandom_range(0, 1))
                begin
                    build_frame(h0, h1, 8'($urandom_range(1, 2)), pick_word(), pick_word());
                    while (frame_buf.size() > len)
                        void'(frame_buf.pop_back());
                end
                else
                begin
                    frame_buf.delete();
                    repeat (len)
                        frame_buf.push_back(8'($urandom_range(0, 255)));
                end
            end
            8:
            begin
                len = $urandom_range(13, 24);
                build_frame(h0, h1, 8'($urandom_range(1, 2)), pick_word(), pick_word());
                while (frame_buf.size() < len)
                    frame_buf.push_back(8'($urandom_range(0, 255)));
            end
            9:
            begin
                frame_buf.delete();
                repeat (12)
                    frame_buf.push_back(8'($urandom_range(0, 255)));
            end
            default:
                build_frame(h0, h1, 8'($urandom_range(1, 2)), pick_word(), pick_word());
        endcase
        queue_frame();
    endtask

    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_took))
        begin
            if (in_gap != 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (wire_bytes.size() != 0)
            begin
                wire_beat_t beat;
                beat = wire_bytes.pop_front();
                in_valid <= 1'b1;
                data_byte <= beat.data;
                last_byte <= beat.last;
                in_gap = draw_wait(in_calm);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (out_took)
            result_wait = draw_wait(out_calm);
        if (rst_n && out_valid && result_wait > 0)
        begin
            out_stall <= 1'b1;
            result_wait--;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_took <= in_valid && !in_stall;
            out_took <= out_valid && !out_stall;
            if (out_valid && !out_stall)
                check_report();
            if (in_valid && !in_stall)
                parse_byte(data_byte, last_byte);
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        build_frame(lfp_pkg::HDR0_BYTE, lfp_pkg::HDR1_BYTE, lfp_pkg::KIND_CURRENT,
                    32'hFFFF_FFFF, 32'h0000_0000);
        queue_frame();
        frame_buf.push_back(8'h00);
        queue_frame();
        build_frame(lfp_pkg::HDR0_BYTE, lfp_pkg::HDR1_BYTE, lfp_pkg::KIND_HOME,
                    32'h0000_0000, 32'hFFFF_FFFF);
        queue_frame();
        while (wire_bytes.size() < STIM_BYTES)
            queue_random_frame();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (wire_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (due_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* location_frame_parser.f */
rtl/core/lfp_pkg.sv
rtl/core/lfp_in_stage.sv
rtl/core/lfp_frame_acc.sv
rtl/core/location_frame_parser.sv
test/location_frame_parser_test.sv
